// ----- src/rps_pkg.sv -----
// Shared types and constants for the rectangle partition slicer.
`timescale 1ns / 1ps
package rps_pkg;

   localparam int COORD_WIDTH    = 16;
   localparam int PIECE_COUNT    = 5;
   localparam int CSR_ADDR_WIDTH = 3;

   // Piece slots, in output order
   localparam int PIECE_TOP    = 0;
   localparam int PIECE_BOTTOM = 1;
   localparam int PIECE_LEFT   = 2;
   localparam int PIECE_RIGHT  = 3;
   localparam int PIECE_INSIDE = 4;

   // Configuration register indexes
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_PART_LEFT   = 3'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_PART_TOP    = 3'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_PART_RIGHT  = 3'd2;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_PART_BOTTOM = 3'd3;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_KEEP_INSIDE = 3'd4;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   localparam coord_type COORD_ONE = coord_type'(1);

   typedef struct packed {
      coord_type left;
      coord_type top;
      coord_type right;
      coord_type bottom;
   } rect_type;

   typedef struct packed {
      rect_type [PIECE_COUNT-1:0] rect;
      logic     [PIECE_COUNT-1:0] valid;
   } piece_set_type;

endpackage

// ----- src/rectangle_partition_slicer_top.sv -----
// An accepted item is registered in the input register; its pieces go out through
// the result register. Throughput: one piece per cycle while rsp_ready holds; an
// item holds the input register until its last piece loads (released at once when
// it yields none), so items that miss the partition flow at one per cycle too. The
// single input register and the one-piece result register set that figure.
// Reset: synchronous, active high; clears valids, partition to 0, keep_inside to 1.
`timescale 1ns / 1ps
module rectangle_partition_slicer_top
   import rps_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_index,
   input  logic [COORD_WIDTH-1:0]    csr_data,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  coord_type                 req_in_left,
   input  coord_type                 req_in_top,
   input  coord_type                 req_in_right,
   input  coord_type                 req_in_bottom,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output coord_type                 rsp_out_left,
   output coord_type                 rsp_out_top,
   output coord_type                 rsp_out_right,
   output coord_type                 rsp_out_bottom,
   output logic                      rsp_is_inside,
   output logic                      rsp_last_piece
);

   rect_type      part_ff, part_in;
   logic          keep_ff, keep_in;
   rect_type      item_ff;
   logic          item_valid_ff, item_valid_in;
   logic          item_done;
   logic          req_accept;
   piece_set_type pieces;

   assign csr_ready  = 1'b1;
   assign req_ready  = !item_valid_ff || item_done;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      part_in = part_ff;
      keep_in = keep_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PART_LEFT:   part_in.left   = coord_type'(csr_data);
            CSR_PART_TOP:    part_in.top    = coord_type'(csr_data);
            CSR_PART_RIGHT:  part_in.right  = coord_type'(csr_data);
            CSR_PART_BOTTOM: part_in.bottom = coord_type'(csr_data);
            CSR_KEEP_INSIDE: keep_in        = csr_data[0];
            default:         ;
         endcase
      end
      item_valid_in = req_accept || (item_valid_ff && !item_done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         part_ff       <= '0;
         keep_ff       <= 1'b1;
         item_valid_ff <= 1'b0;
      end else begin
         part_ff       <= part_in;
         keep_ff       <= keep_in;
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= '{left: req_in_left, top: req_in_top, right: req_in_right,
                      bottom: req_in_bottom};
      end
   end

   rps_cut u_cut (
      .item_rect   (item_ff),
      .part_rect   (part_ff),
      .keep_inside (keep_ff),
      .pieces      (pieces)
   );

   rps_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .item_valid     (item_valid_ff),
      .pieces         (pieces),
      .item_done      (item_done),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_left   (rsp_out_left),
      .rsp_out_top    (rsp_out_top),
      .rsp_out_right  (rsp_out_right),
      .rsp_out_bottom (rsp_out_bottom),
      .rsp_is_inside  (rsp_is_inside),
      .rsp_last_piece (rsp_last_piece)
   );

endmodule

// ----- src/rps_cut.sv -----
// Combinational cut of one rectangle against the partition into up to five pieces.
`timescale 1ns / 1ps
module rps_cut
   import rps_pkg::*;
(
   input  rect_type      item_rect,
   input  rect_type      part_rect,
   input  logic          keep_inside,
   output piece_set_type pieces
);

   coord_type il, it, ir, ib;
   coord_type l, t, r, b;
   coord_type pl, pt, pr, pb;
   coord_type rem_l, rem_t, rem_r, rem_b;
   logic      overlap;

   always_comb begin
      l  = item_rect.left;
      t  = item_rect.top;
      r  = item_rect.right;
      b  = item_rect.bottom;
      pl = part_rect.left;
      pt = part_rect.top;
      pr = part_rect.right;
      pb = part_rect.bottom;

      il = (l > pl) ? l : pl;
      ir = (r < pr) ? r : pr;
      it = (t > pt) ? t : pt;
      ib = (b < pb) ? b : pb;
      overlap = (il <= ir) && (it <= ib);

      // Remainder after each cut equals the intersection edge
      rem_t = it;
      rem_b = ib;
      rem_l = il;
      rem_r = ir;

      pieces.rect[PIECE_TOP]    = '{left: l, top: t, right: r, bottom: coord_type'(pt - COORD_ONE)};
      pieces.rect[PIECE_BOTTOM] = '{left: l, top: coord_type'(pb + COORD_ONE), right: r, bottom: b};
      pieces.rect[PIECE_LEFT]   = '{left: l, top: rem_t, right: coord_type'(pl - COORD_ONE),
                                    bottom: rem_b};
      pieces.rect[PIECE_RIGHT]  = '{left: coord_type'(pr + COORD_ONE), top: rem_t, right: r,
                                    bottom: rem_b};
      pieces.rect[PIECE_INSIDE] = '{left: rem_l, top: rem_t, right: rem_r, bottom: rem_b};

      pieces.valid[PIECE_TOP]    = overlap && (t < pt);
      pieces.valid[PIECE_BOTTOM] = overlap && (b > pb);
      pieces.valid[PIECE_LEFT]   = overlap && (l < pl);
      pieces.valid[PIECE_RIGHT]  = overlap && (r > pr);
      pieces.valid[PIECE_INSIDE] = overlap && keep_inside;

      // No overlap: pass the item through whole in the first slot
      if (!overlap) begin
         pieces.rect[PIECE_TOP]  = item_rect;
         pieces.valid[PIECE_TOP] = 1'b1;
      end
   end

endmodule

// ----- src/rps_emit.sv -----
// Piece sequencer and result register: walks the valid pieces of one item in order.
`timescale 1ns / 1ps
module rps_emit
   import rps_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   input  piece_set_type pieces,
   output logic          item_done,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output coord_type     rsp_out_left,
   output coord_type     rsp_out_top,
   output coord_type     rsp_out_right,
   output coord_type     rsp_out_bottom,
   output logic          rsp_is_inside,
   output logic          rsp_last_piece
);

   logic [PIECE_COUNT-1:0] sent_ff, sent_in;
   logic [PIECE_COUNT-1:0] pend, first;
   logic                   rsp_valid_ff, rsp_valid_in;
   rect_type               rect_ff, rect_in;
   logic                   inside_ff, inside_in;
   logic                   last_ff, last_in;
   logic                   load_ok, last, any;

   always_comb begin
      pend    = item_valid ? (pieces.valid & ~sent_ff) : '0;
      first   = pend & (~pend + 1'b1);
      any     = (pend != '0);
      last    = ((pend & ~first) == '0);
      load_ok = !rsp_valid_ff || rsp_ready;

      // Release the item on its final piece, or at once if it has none
      item_done = item_valid && (!any || (load_ok && last));

      rect_in = rect_ff;
      for (int i = 0; i < PIECE_COUNT; i++) begin
         if (first[i]) begin
            rect_in = pieces.rect[i];
         end
      end
      inside_in = first[PIECE_INSIDE];
      last_in   = last;

      if (item_done) begin
         sent_in = '0;
      end else if (load_ok && any) begin
         sent_in = sent_ff | first;
      end else begin
         sent_in = sent_ff;
      end

      rsp_valid_in = load_ok ? any : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sent_ff      <= sent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ok && any) begin
         rect_ff   <= rect_in;
         inside_ff <= inside_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_left   = rect_ff.left;
   assign rsp_out_top    = rect_ff.top;
   assign rsp_out_right  = rect_ff.right;
   assign rsp_out_bottom = rect_ff.bottom;
   assign rsp_is_inside  = inside_ff;
   assign rsp_last_piece = last_ff;

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the rectangle partition slicer top level.
`timescale 1ns / 1ps
module tb;
   import rps_pkg::*;

   localparam int CLOCK_HALF   = 5;
   localparam int RESET_CYCLES = 11;
   localparam int DRAIN_CYCLES = 8;
   localparam int QUIET_LIMIT  = 3000;
   localparam int LONG_HOLD    = 300;
   localparam int REPORT_MAX   = 10;
   localparam int COORD_MIN    = -32768;
   localparam int COORD_MAX    = 32767;

   // Index outside the register map; a write there must change nothing
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_UNMAPPED = 3'd7;

   typedef struct packed {
      rect_type rect;
      logic     in_part;
      logic     last;
   } slice_piece_type;

   logic                      clock;
   logic                      reset;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_ADDR_WIDTH-1:0] csr_index;
   logic [COORD_WIDTH-1:0]    csr_data;
   logic                      req_valid;
   logic                      req_ready;
   coord_type                 req_in_left;
   coord_type                 req_in_top;
   coord_type                 req_in_right;
   coord_type                 req_in_bottom;
   logic                      rsp_valid;
   logic                      rsp_ready;
   coord_type                 rsp_out_left;
   coord_type                 rsp_out_top;
   coord_type                 rsp_out_right;
   coord_type                 rsp_out_bottom;
   logic                      rsp_is_inside;
   logic                      rsp_last_piece;

   slice_piece_type expected_pieces[$];
   rect_type        part_cfg;
   logic            keep_cfg;
   int              fail_count;
   int              quiet_cycles;
   int              hold_request;
   bit              sender_gaps;

   rectangle_partition_slicer_top u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_left    (req_in_left),
      .req_in_top     (req_in_top),
      .req_in_right   (req_in_right),
      .req_in_bottom  (req_in_bottom),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_left   (rsp_out_left),
      .rsp_out_top    (rsp_out_top),
      .rsp_out_right  (rsp_out_right),
      .rsp_out_bottom (rsp_out_bottom),
      .rsp_is_inside  (rsp_is_inside),
      .rsp_last_piece (rsp_last_piece)
   );

   initial clock = 1'b0;
   always #(CLOCK_HALF) clock = ~clock;

   // Cut one rectangle against the partition and queue the pieces it yields
   function automatic void cut_rectangle(input rect_type box);
      rect_type        rem;
      rect_type        s;
      coord_type       il;
      coord_type       ir;
      coord_type       it;
      coord_type       ib;
      slice_piece_type batch[$];
      rem = box;
      il = (rem.left > part_cfg.left) ? rem.left : part_cfg.left;
      ir = (rem.right < part_cfg.right) ? rem.right : part_cfg.right;
      it = (rem.top > part_cfg.top) ? rem.top : part_cfg.top;
      ib = (rem.bottom < part_cfg.bottom) ? rem.bottom : part_cfg.bottom;
      if (!(il <= ir && it <= ib)) begin
         expected_pieces.push_back('{rect: rem, in_part: 1'b0, last: 1'b1});
         return;
      end
      if (rem.top < part_cfg.top) begin
         s = rem;
         s.bottom = part_cfg.top - COORD_ONE;
         rem.top = part_cfg.top;
         batch.push_back('{rect: s, in_part: 1'b0, last: 1'b0});
      end
      if (rem.bottom > part_cfg.bottom) begin
         s = rem;
         s.top = part_cfg.bottom + COORD_ONE;
         rem.bottom = part_cfg.bottom;
         batch.push_back('{rect: s, in_part: 1'b0, last: 1'b0});
      end
      if (rem.left < part_cfg.left) begin
         s = rem;
         s.right = part_cfg.left - COORD_ONE;
         rem.left = part_cfg.left;
         batch.push_back('{rect: s, in_part: 1'b0, last: 1'b0});
      end
      if (rem.right > part_cfg.right) begin
         s = rem;
         s.left = part_cfg.right + COORD_ONE;
         rem.right = part_cfg.right;
         batch.push_back('{rect: s, in_part: 1'b0, last: 1'b0});
      end
      if (keep_cfg)
         batch.push_back('{rect: rem, in_part: 1'b1, last: 1'b0});
      if (batch.size() > 0)
         batch[batch.size()-1].last = 1'b1;
      foreach (batch[k])
         expected_pieces.push_back(batch[k]);
   endfunction

   function automatic rect_type make_rect(input int l, input int t, input int r, input int b);
      rect_type box;
      box.left   = coord_type'(l);
      box.top    = coord_type'(t);
      box.right  = coord_type'(r);
      box.bottom = coord_type'(b);
      return box;
   endfunction

   function automatic int clamp_coord(input int v);
      if (v < COORD_MIN)
         return COORD_MIN;
      if (v > COORD_MAX)
         return COORD_MAX;
      return v;
   endfunction

   // Coordinate on, next to, near or beyond a partition edge, or anywhere in range
   function automatic coord_type near_anchor(input coord_type anchor);
      int v;
      v = int'(anchor);
      case ($urandom_range(0, 6))
         0: v = v;
         1: v = v - 1;
         2: v = v + 1;
         3: v = v - int'($urandom_range(2, 40));
         4: v = v + int'($urandom_range(2, 40));
         5: v = v + int'($urandom_range(0, 2000)) - 1000;
         default: v = int'(coord_type'($urandom));
      endcase
      return coord_type'(clamp_coord(v));
   endfunction

   function automatic rect_type random_rect();
      rect_type  box;
      coord_type a;
      coord_type b;
      if ($urandom_range(0, 99) < 12) begin
         box.left   = coord_type'($urandom);
         box.top    = coord_type'($urandom);
         box.right  = coord_type'($urandom);
         box.bottom = coord_type'($urandom);
         return box;
      end
      a = near_anchor($urandom_range(0, 1) ? part_cfg.left : part_cfg.right);
      b = near_anchor($urandom_range(0, 1) ? part_cfg.left : part_cfg.right);
      box.left  = (a < b) ? a : b;
      box.right = (a < b) ? b : a;
      a = near_anchor($urandom_range(0, 1) ? part_cfg.top : part_cfg.bottom);
      b = near_anchor($urandom_range(0, 1) ? part_cfg.top : part_cfg.bottom);
      box.top    = (a < b) ? a : b;
      box.bottom = (a < b) ? b : a;
      return box;
   endfunction

   function automatic int pick_gap();
      int r;
      if (!sender_gaps)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_rect(input rect_type box);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_in_left   = box.left;
      req_in_top    = box.top;
      req_in_right  = box.right;
      req_in_bottom = box.bottom;
      req_valid     = 1'b1;
      do @(posedge clock); while (!req_ready);
      cut_rectangle(box);
   endtask

   // Drop valid and wait for every queued piece; optionally let the pipe settle
   task automatic wait_drained(input bit settle);
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_pieces.size() != 0) @(posedge clock);
      if (settle)
         repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_WIDTH-1:0] reg_index,
                            input logic [COORD_WIDTH-1:0] reg_data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = reg_index;
      csr_data  = reg_data;
      do @(posedge clock); while (!csr_ready);
      case (reg_index)
         CSR_PART_LEFT:   part_cfg.left   = coord_type'(reg_data);
         CSR_PART_TOP:    part_cfg.top    = coord_type'(reg_data);
         CSR_PART_RIGHT:  part_cfg.right  = coord_type'(reg_data);
         CSR_PART_BOTTOM: part_cfg.bottom = coord_type'(reg_data);
         CSR_KEEP_INSIDE: keep_cfg        = reg_data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_partition(input int l, input int t, input int r, input int b,
                                input logic [COORD_WIDTH-1:0] keep_data);
      wait_drained(1'b1);
      write_reg(CSR_PART_LEFT,   COORD_WIDTH'(l));
      write_reg(CSR_PART_TOP,    COORD_WIDTH'(t));
      write_reg(CSR_PART_RIGHT,  COORD_WIDTH'(r));
      write_reg(CSR_PART_BOTTOM, COORD_WIDTH'(b));
      write_reg(CSR_KEEP_INSIDE, keep_data);
   endtask

   // Receiver: stretches of steady ready, short and long stalls, forced hold-off
   initial begin : receiver
      int stall_left;
      int free_left;
      int r;
      stall_left = 0;
      free_left  = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
            free_left    = 0;
         end
         if (stall_left > 0) begin
            rsp_ready  = 1'b0;
            stall_left = stall_left - 1;
         end else if (free_left > 0) begin
            rsp_ready = 1'b1;
            free_left = free_left - 1;
         end else begin
            r = $urandom_range(0, 99);
            rsp_ready = 1'b1;
            if (r < 50)
               free_left = $urandom_range(1, 40);
            else if (r < 92)
               stall_left = $urandom_range(1, 3);
            else
               stall_left = $urandom_range(10, 40);
         end
      end
   end

   always @(posedge clock) begin : piece_checker
      slice_piece_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pieces.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
               $display("unexpected piece l=%0d t=%0d r=%0d b=%0d in=%0b last=%0b",
                        rsp_out_left, rsp_out_top, rsp_out_right, rsp_out_bottom,
                        rsp_is_inside, rsp_last_piece);
         end else begin
            want = expected_pieces.pop_front();
            if (rsp_out_left !== want.rect.left || rsp_out_top !== want.rect.top ||
                rsp_out_right !== want.rect.right || rsp_out_bottom !== want.rect.bottom ||
                rsp_is_inside !== want.in_part || rsp_last_piece !== want.last) begin
               fail_count++;
               if (fail_count <= REPORT_MAX) begin
                  $display("piece mismatch: want l=%0d t=%0d r=%0d b=%0d in=%0b last=%0b",
                           want.rect.left, want.rect.top, want.rect.right,
                           want.rect.bottom, want.in_part, want.last);
                  $display("                got  l=%0d t=%0d r=%0d b=%0d in=%0b last=%0b",
                           rsp_out_left, rsp_out_top, rsp_out_right, rsp_out_bottom,
                           rsp_is_inside, rsp_last_piece);
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", quiet_cycles);
         $display("rectangle_partition_slicer_top regression: fail");
         $finish;
      end
   end

   task automatic test_reset_defaults();
      // partition is the single point at the origin, overlap kept
      send_rect(make_rect(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
      send_rect(make_rect(0, 0, 0, 0));
      send_rect(make_rect(1, 1, 5, 5));
      send_rect(make_rect(5, 0, -5, 0));
   endtask

   task automatic test_removal_edges();
      set_partition(-100, -50, 100, 50, 16'h0000);
      send_rect(make_rect(-100, -50, 100, 50));
      send_rect(make_rect(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
      send_rect(make_rect(-10, -60, 10, 0));
      send_rect(make_rect(-200, -10, -100, 10));
      send_rect(make_rect(-200, -10, -101, 10));
      send_rect(make_rect(0, 20, 0, 10));
      wait_drained(1'b1);
      write_reg(CSR_KEEP_INSIDE, 16'hfffe);
      send_rect(make_rect(0, 0, 0, 0));
      wait_drained(1'b1);
      write_reg(CSR_KEEP_INSIDE, 16'h8001);
      send_rect(make_rect(-101, 51, 101, 60));
   endtask

   task automatic test_extreme_partition();
      set_partition(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 16'h0001);
      send_rect(make_rect(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
      send_rect(make_rect(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
      set_partition(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 16'h0001);
      send_rect(make_rect(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
      set_partition(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 16'h0001);
      send_rect(make_rect(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
      send_rect(make_rect(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX));
   endtask

   task automatic test_degenerate_partition();
      set_partition(10, 0, -10, 0, 16'h0001);
      send_rect(make_rect(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
      // unmapped index: the partition must stay as it is
      wait_drained(1'b1);
      write_reg(CSR_UNMAPPED, 16'hffff);
      send_rect(make_rect(-10, 0, 10, 0));
      set_partition(0, 10, 0, -10, 16'h0000);
      send_rect(make_rect(-5, -5, 5, 5));
   endtask

   task automatic test_random_phases();
      int c;
      int w;
      for (int phase = 0; phase < 6; phase++) begin
         c = $urandom_range(0, 64000) - 32000;
         w = $urandom_range(0, 60);
         case (phase)
            0: set_partition(c - w, c - 2 * w, c + w, c + w, 16'h0001);
            1: set_partition(c - w, c - w, c + 2 * w, c + w, 16'h0000);
            2: set_partition(COORD_MIN, COORD_MIN, COORD_MIN + w, COORD_MIN + 2 * w,
                             COORD_WIDTH'($urandom) | 16'h0001);
            3: set_partition(COORD_MAX - w, COORD_MAX - 2 * w, COORD_MAX, COORD_MAX,
                             COORD_WIDTH'($urandom) & 16'hfffe);
            4: set_partition(int'(coord_type'($urandom)), int'(coord_type'($urandom)),
                             int'(coord_type'($urandom)), int'(coord_type'($urandom)),
                             COORD_WIDTH'($urandom));
            default: set_partition(c, c, c, c, 16'h0001);
         endcase
         // one phase runs back to back with no sender gaps
         sender_gaps = (phase != 2);
         repeat (58) send_rect(random_rect());
      end
      sender_gaps = 1'b1;
   endtask

   task automatic test_receiver_hold_off();
      set_partition(-20, -20, 20, 20, 16'h0001);
      sender_gaps  = 1'b0;
      hold_request = LONG_HOLD;
      repeat (24) send_rect(random_rect());
      sender_gaps = 1'b1;
   endtask

   task automatic test_sender_pause();
      set_partition(-1000, 200, 3000, 900, 16'h0000);
      repeat (12) send_rect(random_rect());
      wait_drained(1'b0);
      repeat (12) send_rect(random_rect());
   endtask

   initial begin
      reset         = 1'b1;
      csr_valid     = 1'b0;
      csr_index     = CSR_PART_LEFT;
      csr_data      = '0;
      req_valid     = 1'b0;
      req_in_left   = '0;
      req_in_top    = '0;
      req_in_right  = '0;
      req_in_bottom = '0;
      fail_count    = 0;
      quiet_cycles  = 0;
      hold_request  = 0;
      sender_gaps   = 1'b1;
      part_cfg      = '0;
      keep_cfg      = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_removal_edges();
      test_extreme_partition();
      test_degenerate_partition();
      test_receiver_hold_off();
      test_sender_pause();
      test_random_phases();

      wait_drained(1'b1);
      if (expected_pieces.size() != 0)
         fail_count++;
      if (fail_count == 0)
         $display("rectangle_partition_slicer_top regression: pass");
      else
         $display("rectangle_partition_slicer_top regression: fail");
      $finish;
   end

endmodule
